### hw/rtl/min_sum_of_squares_decompose_core_defines.svh
// assertion helpers used by the checker file
`ifndef MIN_SUM_OF_SQUARES_DECOMPOSE_CORE_DEFINES_SVH
`define MIN_SUM_OF_SQUARES_DECOMPOSE_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define MSQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/msq_pkg.sv
`default_nettype none
package msq_pkg;

    localparam int VALUE_BITS = 16;
    // wide enough for a root plus the loop overrun past the last root
    localparam int ROOT_W     = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_W       = 2 * ROOT_W;
    localparam int PROD_W     = 2 * VALUE_BITS + 1;
    localparam int OUT_W      = 8;
    localparam int CNT_W      = 3;

    // reciprocal of three, exact for every value below 2**VALUE_BITS
    localparam logic [VALUE_BITS:0] RECIP3 =
        (VALUE_BITS + 1)'(((64'd1 << (VALUE_BITS + 1)) + 64'd2) / 64'd3);

    localparam logic [VALUE_BITS-1:0] ISQ_BIT_TOP =
        VALUE_BITS'(1) << (2 * ((VALUE_BITS - 1) / 2));

    typedef enum logic [3:0] {
        S_IDLE,
        S_RT0,
        S_CK0,
        S_RD_RT,
        S_RD_CK,
        S_T3_DIV,
        S_T3_GO,
        S_T3_RT,
        S_T3_CK,
        S_T2_RT,
        S_T2_CK,
        S_T2_SR,
        S_T2_MC,
        S_T2_END,
        S_OUT
    } t_state;

    // value of the form 4^a(8b+7); zero is not
    function automatic logic needs_four(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS+2:0] x;
        logic                  found;
        logic                  res;
        x     = (VALUE_BITS + 3)'(v);
        found = 1'b0;
        res   = 1'b0;
        for (int k = 0; k < (VALUE_BITS + 1) / 2; k++) begin
            if (!found && (x[2*k +: 2] != 2'b00)) begin
                found = 1'b1;
                res   = (x[2*k +: 3] == 3'b111);
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/msq_isqrt.sv
`default_nettype none
module msq_isqrt (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [msq_pkg::VALUE_BITS-1:0]   i_op,
    output logic                                  o_done,
    output logic      [msq_pkg::ROOT_W-1:0]       o_root
);

    logic                               r_act;
    logic                               r_done;
    logic [msq_pkg::VALUE_BITS-1:0]     r_x;
    logic [msq_pkg::VALUE_BITS-1:0]     r_res;
    logic [msq_pkg::VALUE_BITS-1:0]     r_bit;
    logic [msq_pkg::ROOT_W-1:0]         r_root;
    logic [msq_pkg::VALUE_BITS:0]       trial;
    logic                               take;
    logic [msq_pkg::VALUE_BITS-1:0]     n_x;
    logic [msq_pkg::VALUE_BITS-1:0]     n_res;

    // one result bit per cycle, restoring digit method
    always_comb begin
        trial = {1'b0, r_res} + {1'b0, r_bit};
        take  = ({1'b0, r_x} >= trial);
        n_x   = take ? (r_x - trial[msq_pkg::VALUE_BITS-1:0]) : r_x;
        n_res = take ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_act <= 1'b1;
            end else if (r_act && r_bit[0]) begin
                r_act  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_op;
            r_res <= '0;
            r_bit <= msq_pkg::ISQ_BIT_TOP;
        end else if (r_act) begin
            r_x   <= n_x;
            r_res <= n_res;
            r_bit <= r_bit >> 2;
            if (r_bit[0]) begin
                r_root <= n_res[msq_pkg::ROOT_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

### hw/rtl/min_sum_of_squares_decompose_core.sv
// channel   | direction | handshake            | payload
// command   | in        | i_start, o_busy      | i_value_in
// result    | out       | o_done (one cycle)   | o_root_a..o_root_d, o_square_count
//
// a value is taken when i_start is high and o_busy is low; o_busy then stays
// high until the result beat. integer square roots are worked out one at a
// time in the shared root unit, so a perfect square reaches the result beat
// soonest and the nested three-square search takes longest. reset is
// synchronous, active low, and returns to idle. results cannot be held off
// by the receiver.
`default_nettype none
module min_sum_of_squares_decompose_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [15:0]   i_value_in,
    output logic               o_busy,
    output logic               o_done,
    output logic      [7:0]    o_root_a,
    output logic      [7:0]    o_root_b,
    output logic      [7:0]    o_root_c,
    output logic      [7:0]    o_root_d,
    output logic      [2:0]    o_square_count
);

    localparam int VB = msq_pkg::VALUE_BITS;
    localparam int RW = msq_pkg::ROOT_W;
    localparam int SW = msq_pkg::SQ_W;
    localparam int OW = msq_pkg::OUT_W;

    msq_pkg::t_state r_state, n_state;

    logic [VB-1:0]              r_n, r_d3, r_d2, r_r2;
    logic [VB-1:0]              n_n, n_d3, n_d2, n_r2;
    logic [SW-1:0]              r_sq, n_sq;
    logic [RW-1:0]              r_s, r_ri, r_i3, r_i2, r_pa, r_pb;
    logic [RW-1:0]              n_s, n_ri, n_i3, n_i2, n_pa, n_pb;
    logic                       r_hit2, r_from3, r_mode4;
    logic                       n_hit2, n_from3, n_mode4;
    logic [OW-1:0]              r_ra, r_rb, r_rc, r_rd;
    logic [OW-1:0]              n_ra, n_rb, n_rc, n_rd;
    logic [msq_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [msq_pkg::PROD_W-1:0] r_prod, n_prod;

    logic                       iso_start;
    logic [VB-1:0]              iso_op;
    logic                       iso_done;
    logic [RW-1:0]              iso_root;

    logic [RW-1:0]              sq_op;
    logic [SW-1:0]              sq_val;
    logic                       sq_eq_n, sq_lt_n, sq_lt_d3, sq_lt_d2, sq_eq_r2;
    logic [VB-1:0]              n_minus_sq, d3_minus_sq, d2_minus_sq;
    logic                       four_n, four_diff;

    msq_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (iso_start),
        .i_op    (iso_op),
        .o_done  (iso_done),
        .o_root  (iso_root)
    );

    // compares shared by state and data logic
    always_comb begin
        sq_eq_n     = (r_sq == SW'(r_n));
        sq_lt_n     = (r_sq <  SW'(r_n));
        sq_lt_d3    = (r_sq <  SW'(r_d3));
        sq_lt_d2    = (r_sq <  SW'(r_d2));
        sq_eq_r2    = (r_sq == SW'(r_r2));
        n_minus_sq  = r_n  - r_sq[VB-1:0];
        d3_minus_sq = r_d3 - r_sq[VB-1:0];
        d2_minus_sq = r_d2 - r_sq[VB-1:0];
        four_n      = msq_pkg::needs_four(r_n);
        four_diff   = msq_pkg::needs_four(n_minus_sq);
    end

    // shared squarer: new root, or next loop index
    always_comb begin
        case (r_state)
            msq_pkg::S_RD_CK:  sq_op = r_ri + RW'(1);
            msq_pkg::S_T2_MC:  sq_op = r_i2 + RW'(1);
            msq_pkg::S_T2_END: sq_op = r_i3 + RW'(1);
            default:           sq_op = iso_root;
        endcase
        sq_val = SW'(sq_op) * SW'(sq_op);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            msq_pkg::S_IDLE:   if (i_start) n_state = msq_pkg::S_RT0;
            msq_pkg::S_RT0:    if (iso_done) n_state = msq_pkg::S_CK0;
            msq_pkg::S_CK0: begin
                if (sq_eq_n)     n_state = msq_pkg::S_OUT;
                else if (four_n) n_state = msq_pkg::S_RD_RT;
                else             n_state = msq_pkg::S_T2_RT;
            end
            msq_pkg::S_RD_RT:  if (iso_done) n_state = msq_pkg::S_RD_CK;
            msq_pkg::S_RD_CK: begin
                if (!sq_lt_n || !four_diff) n_state = msq_pkg::S_T3_DIV;
            end
            msq_pkg::S_T3_DIV: n_state = msq_pkg::S_T3_GO;
            msq_pkg::S_T3_GO:  n_state = msq_pkg::S_T3_RT;
            msq_pkg::S_T3_RT:  if (iso_done) n_state = msq_pkg::S_T3_CK;
            msq_pkg::S_T3_CK:  n_state = sq_lt_d3 ? msq_pkg::S_T2_RT : msq_pkg::S_OUT;
            msq_pkg::S_T2_RT:  if (iso_done) n_state = msq_pkg::S_T2_CK;
            msq_pkg::S_T2_CK:  n_state = sq_lt_d2 ? msq_pkg::S_T2_SR : msq_pkg::S_T2_END;
            msq_pkg::S_T2_SR:  if (iso_done) n_state = msq_pkg::S_T2_MC;
            msq_pkg::S_T2_MC:  n_state = msq_pkg::S_T2_CK;
            msq_pkg::S_T2_END: begin
                if (r_hit2)       n_state = msq_pkg::S_OUT;
                else if (r_from3) n_state = msq_pkg::S_T3_CK;
                else              n_state = msq_pkg::S_T3_DIV;
            end
            msq_pkg::S_OUT:    n_state = msq_pkg::S_IDLE;
            default:           n_state = msq_pkg::S_IDLE;
        endcase
    end

    // root unit launches
    always_comb begin
        iso_start = 1'b0;
        iso_op    = '0;
        case (r_state)
            msq_pkg::S_IDLE: begin
                iso_start = i_start;
                iso_op    = VB'(i_value_in);
            end
            msq_pkg::S_CK0: begin
                iso_start = !sq_eq_n;
                iso_op    = four_n ? (r_n >> 2) : (r_n >> 1);
            end
            msq_pkg::S_T3_GO: begin
                iso_start = 1'b1;
                iso_op    = r_prod[msq_pkg::PROD_W-1:VB+1];
            end
            msq_pkg::S_T3_CK: begin
                iso_start = sq_lt_d3;
                iso_op    = d3_minus_sq >> 1;
            end
            msq_pkg::S_T2_CK: begin
                iso_start = sq_lt_d2;
                iso_op    = d2_minus_sq;
            end
            default: begin
                iso_start = 1'b0;
                iso_op    = '0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_n = r_n;   n_d3 = r_d3; n_d2 = r_d2; n_r2 = r_r2;
        n_sq = r_sq; n_s = r_s;   n_ri = r_ri; n_i3 = r_i3; n_i2 = r_i2;
        n_pa = r_pa; n_pb = r_pb; n_hit2 = r_hit2; n_from3 = r_from3;
        n_mode4 = r_mode4; n_prod = r_prod;
        n_ra = r_ra; n_rb = r_rb; n_rc = r_rc; n_rd = r_rd; n_cnt = r_cnt;
        case (r_state)
            msq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_n  = VB'(i_value_in);
                    n_ra = '0; n_rb = '0; n_rc = '0; n_rd = '0; n_cnt = '0;
                end
            end
            msq_pkg::S_RT0: begin
                if (iso_done) begin
                    n_s  = iso_root;
                    n_sq = sq_val;
                end
            end
            msq_pkg::S_CK0: begin
                if (sq_eq_n) begin
                    n_ra  = r_s[OW-1:0];
                    n_cnt = 3'd1;
                end else if (!four_n) begin
                    n_d2    = r_n;
                    n_from3 = 1'b0;
                end
            end
            msq_pkg::S_RD_RT: begin
                if (iso_done) begin
                    n_ri = iso_root;
                    n_sq = sq_val;
                end
            end
            msq_pkg::S_RD_CK: begin
                n_mode4 = 1'b1;
                if (sq_lt_n) begin
                    if (!four_diff) begin
                        n_rd = r_ri[OW-1:0];
                        n_d3 = n_minus_sq;
                    end else begin
                        n_ri = r_ri + RW'(1);
                        n_sq = sq_val;
                    end
                end else begin
                    n_rd = '0;
                    n_d3 = r_n;
                end
            end
            msq_pkg::S_T3_DIV: begin
                n_prod = msq_pkg::PROD_W'(r_d3) * msq_pkg::PROD_W'(msq_pkg::RECIP3);
            end
            msq_pkg::S_T3_RT: begin
                if (iso_done) begin
                    n_i3 = iso_root;
                    n_sq = sq_val;
                end
            end
            msq_pkg::S_T3_CK: begin
                if (sq_lt_d3) begin
                    n_d2    = d3_minus_sq;
                    n_from3 = 1'b1;
                end else begin
                    n_ra  = '0; n_rb = '0; n_rc = '0;
                    n_cnt = r_mode4 ? 3'd4 : 3'd0;
                end
            end
            msq_pkg::S_T2_RT: begin
                if (iso_done) begin
                    n_i2   = iso_root;
                    n_sq   = sq_val;
                    n_hit2 = 1'b0;
                end
            end
            msq_pkg::S_T2_CK: begin
                if (sq_lt_d2) n_r2 = d2_minus_sq;
            end
            msq_pkg::S_T2_SR: begin
                if (iso_done) begin
                    n_s  = iso_root;
                    n_sq = sq_val;
                end
            end
            msq_pkg::S_T2_MC: begin
                // later match replaces an earlier one
                if (sq_eq_r2) begin
                    n_pa   = r_i2;
                    n_pb   = r_s;
                    n_hit2 = 1'b1;
                end
                n_i2 = r_i2 + RW'(1);
                n_sq = sq_val;
            end
            msq_pkg::S_T2_END: begin
                if (r_hit2) begin
                    n_ra = r_pa[OW-1:0];
                    n_rb = r_pb[OW-1:0];
                    if (r_from3) begin
                        n_rc  = r_i3[OW-1:0];
                        n_cnt = r_mode4 ? 3'd4 : 3'd3;
                    end else begin
                        n_cnt = 3'd2;
                    end
                end else if (r_from3) begin
                    n_i3 = r_i3 + RW'(1);
                    n_sq = sq_val;
                end else begin
                    n_d3    = r_n;
                    n_mode4 = 1'b0;
                end
            end
            default: begin
                n_n = r_n;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;   r_d3 <= n_d3; r_d2 <= n_d2; r_r2 <= n_r2;
        r_sq <= n_sq; r_s <= n_s;   r_ri <= n_ri; r_i3 <= n_i3; r_i2 <= n_i2;
        r_pa <= n_pa; r_pb <= n_pb; r_hit2 <= n_hit2; r_from3 <= n_from3;
        r_mode4 <= n_mode4; r_prod <= n_prod;
        r_ra <= n_ra; r_rb <= n_rb; r_rc <= n_rc; r_rd <= n_rd; r_cnt <= n_cnt;
    end

    assign o_busy         = (r_state != msq_pkg::S_IDLE);
    assign o_done         = (r_state == msq_pkg::S_OUT);
    assign o_root_a       = r_ra;
    assign o_root_b       = r_rb;
    assign o_root_c       = r_rc;
    assign o_root_d       = r_rd;
    assign o_square_count = r_cnt;

endmodule
`default_nettype wire

### hw/rtl/msq_checker.sv
`default_nettype none
`include "min_sum_of_squares_decompose_core_defines.svh"
module msq_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_start,
    input wire logic          o_busy,
    input wire logic          o_done,
    input wire logic [7:0]    o_root_b,
    input wire logic [7:0]    o_root_c,
    input wire logic [7:0]    o_root_d,
    input wire logic [2:0]    o_square_count
);

    // a result beat only closes work that was started
    `MSQ_ASSERT_IMP(a_done_after_busy, o_done, $past(o_busy) && o_busy, "result without work")
    // back to idle right after the result beat
    `MSQ_ASSERT_NXT(a_idle_after_done, o_done, !o_busy && !o_done, "no return to idle")
    // a fresh command always starts work
    `MSQ_ASSERT_NXT(a_start_busy, i_start && !o_busy, o_busy, "command not taken")
    // single square leaves the other roots clear
    `MSQ_ASSERT_IMP(a_one_root, o_done && (o_square_count == 3'd1), (o_root_b == 8'd0) && (o_root_c == 8'd0) && (o_root_d == 8'd0), "unused roots set")

endmodule

bind min_sum_of_squares_decompose_core msq_checker u_msq_checker (.*);
`default_nettype wire

### sim/tb_min_sum_of_squares_decompose_core.sv
`default_nettype none
module tb_min_sum_of_squares_decompose_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 400000;

    typedef struct {
        logic [15:0] value;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [2:0]  count;
    } t_squares;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic [15:0] i_value_in;
    logic        o_busy;
    logic        o_done;
    logic [7:0]  o_root_a;
    logic [7:0]  o_root_b;
    logic [7:0]  o_root_c;
    logic [7:0]  o_root_d;
    logic [2:0]  o_square_count;

    t_squares pending_roots[$];
    int       mismatches = 0;
    int       stall_cycles;

    min_sum_of_squares_decompose_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_value_in     (i_value_in),
        .o_busy         (o_busy),
        .o_done         (o_done),
        .o_root_a       (o_root_a),
        .o_root_b       (o_root_b),
        .o_root_c       (o_root_c),
        .o_root_d       (o_root_d),
        .o_square_count (o_square_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r;
        r = 0;
        for (int k = 16; k >= 0; k--) begin
            if ((r + (64'd1 << k)) * (r + (64'd1 << k)) <= x)
                r = r + (64'd1 << k);
        end
        return r;
    endfunction

    function automatic bit is_four_form(input longint unsigned v);
        if (v == 0)
            return 1'b0;
        while ((v & 3) == 0)
            v = v >> 2;
        return (v & 7) == 7;
    endfunction

    // keeps the last matching pair
    function automatic bit find_pair(input longint unsigned v,
                                     output longint unsigned pa,
                                     output longint unsigned pb);
        bit              hit;
        longint unsigned s;
        hit = 1'b0;
        pa  = 0;
        pb  = 0;
        for (longint unsigned i = floor_root(v >> 1); i * i < v; i++) begin
            s = floor_root(v - i * i);
            if (s * s == v - i * i) begin
                pa  = i;
                pb  = s;
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // keeps the first i whose remainder splits into two squares
    function automatic bit find_triple(input longint unsigned v,
                                       output longint unsigned pa,
                                       output longint unsigned pb,
                                       output longint unsigned pc);
        longint unsigned x;
        longint unsigned y;
        pa = 0;
        pb = 0;
        pc = 0;
        for (longint unsigned i = floor_root(v / 3); i * i < v; i++) begin
            if (find_pair(v - i * i, x, y)) begin
                pa = x;
                pb = y;
                pc = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_squares predict_squares(input logic [15:0] value);
        t_squares        res;
        longint unsigned n, s, ra, rb, rc, rd, cnt;
        n   = value;
        ra  = 0;
        rb  = 0;
        rc  = 0;
        rd  = 0;
        cnt = 0;
        s   = floor_root(n);
        if (s * s == n) begin
            ra  = s;
            cnt = 1;
        end else if (is_four_form(n)) begin
            for (longint unsigned i = floor_root(n / 4); i * i < n; i++) begin
                if (!is_four_form(n - i * i)) begin
                    rd = i;
                    break;
                end
            end
            void'(find_triple(n - rd * rd, ra, rb, rc));
            cnt = 4;
        end else if (find_pair(n, ra, rb)) begin
            cnt = 2;
        end else if (find_triple(n, ra, rb, rc)) begin
            cnt = 3;
        end
        res.value = value;
        res.a     = ra[7:0];
        res.b     = rb[7:0];
        res.c     = rc[7:0];
        res.d     = rd[7:0];
        res.count = cnt[2:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_value(input logic [15:0] value);
        int gap;
        gap = $urandom_range(0, 12);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_value_in <= value;
        do
            @(posedge i_clk);
        while (o_busy);
        pending_roots.push_back(predict_squares(value));
    endtask

    always @(posedge i_clk) begin
        t_squares exp_r;
        if (i_rst_n && o_done) begin
            if (pending_roots.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                exp_r = pending_roots.pop_front();
                if (o_root_a !== exp_r.a)
                    report_mismatch($sformatf("n=%0d root_a %0d exp %0d",
                                              exp_r.value, o_root_a, exp_r.a));
                if (o_root_b !== exp_r.b)
                    report_mismatch($sformatf("n=%0d root_b %0d exp %0d",
                                              exp_r.value, o_root_b, exp_r.b));
                if (o_root_c !== exp_r.c)
                    report_mismatch($sformatf("n=%0d root_c %0d exp %0d",
                                              exp_r.value, o_root_c, exp_r.c));
                if (o_root_d !== exp_r.d)
                    report_mismatch($sformatf("n=%0d root_d %0d exp %0d",
                                              exp_r.value, o_root_d, exp_r.d));
                if (o_square_count !== exp_r.count)
                    report_mismatch($sformatf("n=%0d count %0d exp %0d",
                                              exp_r.value, o_square_count,
                                              exp_r.count));
            end
        end
    end

    // counts cycles in which no beat moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic test_directed();
        logic [15:0] corners[$];
        corners = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7,
                    16'd12, 16'd14, 16'd15, 16'd28, 16'd60, 16'd112, 16'd28672,
                    16'd65025, 16'd65024, 16'd65026, 16'd65534, 16'd65535,
                    16'd32768, 16'd21845, 16'd43690, 16'd255, 16'd65519};
        foreach (corners[k])
            send_value(corners[k]);
    endtask

    task automatic test_random();
        logic [15:0] v;
        int          sel;
        int          a;
        for (int k = 0; k < 300; k++) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1: begin
                    // 4^a(8b+7) values force the reduction step
                    a = $urandom_range(0, 6);
                    v = 16'(((($urandom_range(0, (65535 >> (2 * a)) / 8) * 8) + 7)
                            << (2 * a)));
                    if (v[2:0] != 3'd7 && (v >> (2 * a)) % 8 != 7)
                        v = 16'd7;
                end
                2: begin
                    a = $urandom_range(0, 255);
                    v = 16'(a * a);
                end
                3: v = 16'($urandom_range(0, 300));
                default: v = 16'($urandom);
            endcase
            send_value(v);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_value_in   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        @(posedge i_clk);
        i_start <= 1'b0;
        while (pending_roots.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
